FILE: sv/mme_pkg.sv
`timescale 1ns / 1ps

package mme_pkg;

  // request kinds
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  // which store a load goes to
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [1:0] CFG_COLS_B    = 2'd2;

  localparam logic [3:0] DIM_RESET = 4'd8;

  // sum of up to eight 31-bit magnitude products
  localparam int ACC_W = 35;

  typedef struct packed {
    logic              req_type;
    logic              which_matrix;
    logic [2:0]        elem_row;
    logic [2:0]        elem_col;
    logic signed [15:0] elem_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] prod_value;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic               last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_MAC
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic issue;
    logic first;
    logic last_k;
    logic last_elem;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic res_free;
  } dp_status_t;

endpackage

FILE: sv/mme_datapath.sv
`timescale 1ns / 1ps

module mme_datapath import mme_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int IW      = 3,
  parameter int AW      = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [15:0] wr_value,
  input  logic [AW-1:0]      rd_addr_a,
  input  logic [AW-1:0]      rd_addr_b,
  input  logic [IW-1:0]      row_idx,
  input  logic [IW-1:0]      col_idx,
  output dp_status_t         status,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_t               rsp_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [15:0] mem_a [DEPTH];
  logic [15:0] mem_b [DEPTH];

  // stage 1: read data
  logic signed [15:0] a_q;
  logic signed [15:0] b_q;
  logic               v1;
  logic               first1;
  logic               last1;

  // stage 2: product
  logic signed [31:0] prod;
  logic               v2;
  logic               first2;
  logic               last2;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] sum;
  logic signed [31:0]      sat;
  logic                    in_range;

  // tag of the element in flight
  logic [IW-1:0] row_q;
  logic [IW-1:0] col_q;
  logic          last_q;

  rsp_t rsp_q;
  logic rsp_v;

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= wr_value;
    end
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= wr_value;
    end
    if (cmd.issue) begin
      a_q <= mem_a[rd_addr_a];
      b_q <= mem_b[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= cmd.first;
    last1  <= cmd.last_k;
    prod   <= a_q * b_q;
    first2 <= first1;
    last2  <= last1;
    if (v2) begin
      acc <= sum;
    end
    if (cmd.issue && cmd.first) begin
      row_q  <= row_idx;
      col_q  <= col_idx;
      last_q <= cmd.last_elem;
    end
  end

  always_comb begin
    sum      = first2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    // fits when the sign bit of a 32-bit word and all bits above it agree
    in_range = (&sum[ACC_W-1:31]) || !(|sum[ACC_W-1:31]);
    if (in_range) begin
      sat = sum[31:0];
    end else if (sum[ACC_W-1]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_v <= 1'b0;
    end else if (v2 && last2) begin
      rsp_v <= 1'b1;
    end else if (rsp_v && !rsp_stall) begin
      rsp_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && last2) begin
      rsp_q.prod_value <= sat;
      rsp_q.out_row    <= 3'(row_q);
      rsp_q.out_col    <= 3'(col_q);
      rsp_q.last       <= last_q;
    end
  end

  assign rsp_valid       = rsp_v;
  assign rsp_data        = rsp_q;
  assign status.busy     = v1 || v2;
  assign status.res_free = !rsp_v || !rsp_stall;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (v2 && last2) |-> !(rsp_v && rsp_stall))
    else $error("finished sum would overwrite a stalled result");

  a_one_sum: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.first) |-> !v1 && !v2)
    else $error("new sum started while another is in the pipe");

endmodule

FILE: sv/mme_ctrl.sv
`timescale 1ns / 1ps

module mme_ctrl import mme_pkg::*; #(
  parameter int MAX_DIM = 8,
  parameter int IW      = 3,
  parameter int AW      = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [3:0]         cfg_wdata,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req_data,
  input  dp_status_t         status,
  output dp_cmd_t            cmd,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr_a,
  output logic [AW-1:0]      rd_addr_b,
  output logic [IW-1:0]      row_idx,
  output logic [IW-1:0]      col_idx
);

  localparam logic [AW-1:0] STRIDE = AW'(MAX_DIM);
  localparam logic [3:0]    DIM_MAX = 4'(MAX_DIM);

  ctl_state_t state, state_next;

  logic [3:0] rows_a;
  logic [3:0] inner_dim;
  logic [3:0] cols_b;
  logic [3:0] nr;
  logic [3:0] nk;
  logic [3:0] nc;

  logic [IW-1:0] i, i_next;
  logic [IW-1:0] j, j_next;
  logic [IW-1:0] k, k_next;

  logic load_ok;
  logic i_end;
  logic j_end;
  logic k_end;

  function automatic logic [3:0] eff_dim(input logic [3:0] v);
    if (v == 4'd0) begin
      return 4'd1;
    end else if (v > DIM_MAX) begin
      return DIM_MAX;
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROWS_A:    rows_a    <= cfg_wdata;
        CFG_INNER_DIM: inner_dim <= cfg_wdata;
        CFG_COLS_B:    cols_b    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nr = eff_dim(rows_a);
  assign nk = eff_dim(inner_dim);
  assign nc = eff_dim(cols_b);

  assign i_end = 4'(i) == nr - 4'd1;
  assign j_end = 4'(j) == nc - 4'd1;
  assign k_end = 4'(k) == nk - 4'd1;

  assign load_ok = ({1'b0, req_data.elem_row} < DIM_MAX)
                && ({1'b0, req_data.elem_col} < DIM_MAX);

  assign wr_addr   = AW'(req_data.elem_row) * STRIDE + AW'(req_data.elem_col);
  assign rd_addr_a = AW'(i) * STRIDE + AW'(k);
  assign rd_addr_b = AW'(k) * STRIDE + AW'(j);
  assign row_idx   = i;
  assign col_idx   = j;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          if (req_data.req_type == REQ_LOAD) begin
            cmd.wr_a = load_ok && (req_data.which_matrix == SEL_A);
            cmd.wr_b = load_ok && (req_data.which_matrix == SEL_B);
          end else begin
            i_next     = '0;
            j_next     = '0;
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (!status.busy && status.res_free) begin
          k_next     = '0;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.issue     = 1'b1;
        cmd.first     = (k == '0);
        cmd.last_k    = k_end;
        cmd.last_elem = i_end && j_end;
        if (k_end) begin
          if (j_end) begin
            j_next = '0;
            if (i_end) begin
              state_next = ST_IDLE;
            end else begin
              i_next     = i + 1'b1;
              state_next = ST_WAIT;
            end
          end else begin
            j_next     = j + 1'b1;
            state_next = ST_WAIT;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_load_apart: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !cmd.wr_a && !cmd.wr_b)
    else $error("store write during a sum");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && cmd.last_k && cmd.last_elem) |=> state == ST_IDLE)
    else $error("controller did not return to idle after the last element");

endmodule

FILE: sv/matrix_multiply_engine.sv
`timescale 1ns / 1ps

// channel  direction  handshake                word
// req      in         req_valid / req_stall    req_t: load one element or compute
// rsp      out        rsp_valid / rsp_stall    rsp_t: one element of C, row-major
// cfg      in         cfg_we (no wait)         cfg_idx, cfg_wdata
//
// a load is written to its store at the accepting edge
// a compute walks the elements of C in turn: inner_dim reads through the single
// multiply-accumulate, then a drain of the read/multiply/accumulate stages into
// the output register before the next element starts
// req stalls for the whole compute; a stalled rsp holds the next sum back
// synchronous reset clears control and sets config to DIM_RESET; the stores are not cleared

module matrix_multiply_engine import mme_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [3:0] cfg_wdata,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req_data,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp_data
);

  // index and store address widths
  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [IW-1:0] row_idx;
  logic [IW-1:0] col_idx;

  // sequencer: config registers, loop counters i/j/k, store addresses
  mme_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IW      (IW),
    .AW      (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .status    (status),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .row_idx   (row_idx),
    .col_idx   (col_idx)
  );

  // stores, multiply-accumulate pipe, saturation and output register
  mme_datapath #(
    .MAX_DIM (MAX_DIM),
    .IW      (IW),
    .AW      (AW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .wr_value  (req_data.elem_value),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .row_idx   (row_idx),
    .col_idx   (col_idx),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

FILE: tb/sv/matrix_multiply_engine_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;
  import mme_pkg::*;

  localparam int MAX_DIM = 8;
  // index past the register list, writes to it are dropped
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // cycles the block may still be busy after its last word
  localparam int SETTLE_CYCLES = 16;
  // long receiver hold-off, placed after this many result words
  localparam int HOLD_AT = 120;
  localparam int HOLD_LEN = 500;
  localparam int PHASE_ITEMS = 50;

  // expected product of the loaded stores under the current dimensions
  class matmul_checker;
    logic signed [15:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [15:0] b_mem [MAX_DIM*MAX_DIM];
    logic [3:0] dim_reg [3];
    rsp_t due_elems [$];
    int errors;

    function new();
      foreach (a_mem[n]) begin
        a_mem[n] = '0;
        b_mem[n] = '0;
      end
      foreach (dim_reg[n]) dim_reg[n] = DIM_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [3:0] val);
      if (idx <= CFG_COLS_B) dim_reg[idx] = val;
    endfunction

    // zero acts as one, anything above the store size as the store size
    function int unsigned span(logic [1:0] idx);
      if (dim_reg[idx] == 0) return 1;
      if (dim_reg[idx] > MAX_DIM) return MAX_DIM;
      return dim_reg[idx];
    endfunction

    function void note_word(req_t w);
      int unsigned nr, nk, nc;
      longint acc;
      rsp_t e;
      if (w.req_type == REQ_LOAD) begin
        if (w.which_matrix == SEL_A) a_mem[w.elem_row * MAX_DIM + w.elem_col] = w.elem_value;
        else b_mem[w.elem_row * MAX_DIM + w.elem_col] = w.elem_value;
        return;
      end
      nr = span(CFG_ROWS_A);
      nk = span(CFG_INNER_DIM);
      nc = span(CFG_COLS_B);
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          acc = 0;
          for (int k = 0; k < nk; k++)
            acc += longint'(a_mem[i * MAX_DIM + k]) * longint'(b_mem[k * MAX_DIM + j]);
          // saturate to signed 32-bit
          if (acc > 64'sd2147483647) acc = 64'sd2147483647;
          if (acc < -64'sd2147483648) acc = -64'sd2147483648;
          e.prod_value = acc[31:0];
          e.out_row = 3'(i);
          e.out_col = 3'(j);
          e.last = (i == nr - 1) && (j == nc - 1);
          due_elems.push_back(e);
        end
      end
    endfunction

    task report(string what);
      $display("%0t ns  mismatch: %s", $time, what);
      errors++;
    endtask

    task check_word(rsp_t got);
      rsp_t want;
      if (due_elems.size() == 0) begin
        report($sformatf("result word %h with nothing due", got));
        return;
      end
      want = due_elems.pop_front();
      if (got.prod_value !== want.prod_value)
        report($sformatf("C[%0d][%0d] value %h, want %h", want.out_row, want.out_col,
                         got.prod_value, want.prod_value));
      if (got.out_row !== want.out_row)
        report($sformatf("C[%0d][%0d] row %h", want.out_row, want.out_col, got.out_row));
      if (got.out_col !== want.out_col)
        report($sformatf("C[%0d][%0d] col %h", want.out_row, want.out_col, got.out_col));
      if (got.last !== want.last)
        report($sformatf("C[%0d][%0d] last %b, want %b", want.out_row, want.out_col,
                         got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [3:0] cfg_wdata;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp_data;

  matmul_checker chk = new();

  // which store entries hold a value; a compute never reads an unwritten one
  bit a_done [MAX_DIM*MAX_DIM];
  bit b_done [MAX_DIM*MAX_DIM];
  int unsigned n_items = 0;
  int unsigned tx_gap_max = 19;
  int unsigned rx_gap_max = 19;

  always #5 clk = ~clk;

  matrix_multiply_engine #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  // offer one word after a random gap, return at the accepting edge;
  // valid stays up so a following word with no gap goes out back to back
  task automatic send_word(req_t w);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req_data = w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    chk.note_word(w);
    n_items++;
  endtask

  task automatic send_load(logic sel, logic [2:0] r, logic [2:0] c, logic [15:0] v);
    req_t w;
    w.req_type = REQ_LOAD;
    w.which_matrix = sel;
    w.elem_row = r;
    w.elem_col = c;
    w.elem_value = v;
    send_word(w);
    if (sel == SEL_A) a_done[r * MAX_DIM + c] = 1'b1;
    else b_done[r * MAX_DIM + c] = 1'b1;
  endtask

  // operand fields of a compute are junk the block must ignore
  task automatic send_compute();
    req_t w;
    w = req_t'($urandom);
    w.req_type = REQ_COMPUTE;
    send_word(w);
  endtask

  // half full-range random values, half picked from 8000, 7fff, 0000 and ffff to reach saturation
  function automatic logic [15:0] pick_value();
    unique case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // load every entry the next compute reads that has not been written yet
  task automatic fill_operands();
    int unsigned nr, nk, nc;
    nr = chk.span(CFG_ROWS_A);
    nk = chk.span(CFG_INNER_DIM);
    nc = chk.span(CFG_COLS_B);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_done[i * MAX_DIM + k]) send_load(SEL_A, 3'(i), 3'(k), pick_value());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_done[k * MAX_DIM + j]) send_load(SEL_B, 3'(k), 3'(j), pick_value());
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(posedge clk);
    chk.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_dims(logic [3:0] r, logic [3:0] k, logic [3:0] c);
    write_reg(CFG_ROWS_A, r);
    write_reg(CFG_INNER_DIM, k);
    write_reg(CFG_COLS_B, c);
    write_reg(CFG_SPARE, 4'($urandom));
  endtask

  // drop valid, wait out every due word, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    req_valid = 1'b0;
    while (chk.due_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random loads with a compute now and then; each compute gets its operands first
  task automatic run_phase();
    int unsigned first, n_comp;
    first = n_items;
    n_comp = 0;
    while (n_items - first < PHASE_ITEMS || n_comp == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        fill_operands();
        send_compute();
        n_comp++;
      end else begin
        send_load(1'($urandom), 3'($urandom), 3'($urandom), pick_value());
      end
    end
  endtask

  // receiver: sample at the rising edge, drive stall at the falling edge
  initial begin : rsp_side
    int unsigned wait_left;
    int unsigned n_rsp;
    wait_left = 0;
    n_rsp = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
        chk.check_word(rsp_data);
        n_rsp++;
        // one long hold-off so the engine backs up into the request side
        wait_left = (n_rsp == HOLD_AT) ? HOLD_LEN : $urandom_range(0, rx_gap_max);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      @(negedge clk);
      rsp_stall = (wait_left > 0);
    end
  end

  initial begin : stimulus
    int unsigned plan [7][3];
    plan = '{'{1, 1, 1}, '{8, 8, 8}, '{0, 0, 0}, '{15, 15, 15},
             '{3, 8, 1}, '{8, 1, 5}, '{0, 15, 9}};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = CFG_ROWS_A;
    cfg_wdata = '0;
    req_valid = 1'b0;
    req_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 2x3 times 3x2 with saturation both ways
    set_dims(4'd2, 4'd3, 4'd2);
    // row 0 of A and column 0 of B all most-negative: sum overflows high
    // column 1 of B all most-positive: row 0 sum overflows low
    for (int k = 0; k < 3; k++) begin
      send_load(SEL_A, 3'd0, 3'(k), 16'h8000);
      send_load(SEL_B, 3'(k), 3'd0, 16'h8000);
      send_load(SEL_B, 3'(k), 3'd1, 16'h7fff);
    end
    send_load(SEL_A, 3'd1, 3'd0, 16'h7fff);
    send_load(SEL_A, 3'd1, 3'd1, 16'h0000);
    send_load(SEL_A, 3'd1, 3'd2, 16'hffff);
    // far corner of both stores, outside the product
    send_load(SEL_A, 3'd7, 3'd7, 16'h1234);
    send_load(SEL_B, 3'd7, 3'd7, 16'hedcb);
    begin : junk_compute
      req_t w;
      w.req_type = REQ_COMPUTE;
      w.which_matrix = SEL_B;
      w.elem_row = 3'd7;
      w.elem_col = 3'd7;
      w.elem_value = 16'hffff;
      send_word(w);
    end
    settle();

    // random phases through the dimension corners, idle mix varies per phase
    for (int p = 0; p < 9; p++) begin
      tx_gap_max = (p % 3 == 1) ? 0 : 19;
      rx_gap_max = (p % 4 == 3) ? 0 : 19;
      if (p < 7) set_dims(4'(plan[p][0]), 4'(plan[p][1]), 4'(plan[p][2]));
      else set_dims(4'($urandom), 4'($urandom), 4'($urandom));
      run_phase();
      settle();
    end

    if (chk.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // roughly five times the run with every word a full 8x8 product under the longest stalls
  initial begin : watchdog
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
